>>> rtl/aciasp_pkg.sv
// shared types, register codes and bit masks for the acia serial port register block
// no dependencies; imported by aciasp_qmem and acia_serial_port_registers_core
package aciasp_pkg;

	localparam int QUEUE_DEPTH_DEF   = 1024;
	localparam int POLL_INTERVAL_DEF = 64;

	// request types
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// register selects
	localparam logic [1:0] ADDR_DATA    = 2'd0;
	localparam logic [1:0] ADDR_STATUS  = 2'd1;
	localparam logic [1:0] ADDR_COMMAND = 2'd2;
	localparam logic [1:0] ADDR_CONTROL = 2'd3;

	// status bits
	localparam logic [7:0] ST_PE   = 8'h01;
	localparam logic [7:0] ST_FE   = 8'h02;
	localparam logic [7:0] ST_OVR  = 8'h04;
	localparam logic [7:0] ST_RDRF = 8'h08;
	localparam logic [7:0] ST_TDRE = 8'h10;
	localparam logic [7:0] ST_DCD  = 8'h20;
	localparam logic [7:0] ST_DSR  = 8'h40;
	localparam logic [7:0] ST_IRQ  = 8'h80;
	localparam logic [7:0] ST_RESET = ST_TDRE;

	// command bits
	localparam logic [7:0] CMD_DTR     = 8'h01;
	localparam logic [7:0] CMD_IRD     = 8'h02;
	localparam logic [7:0] CMD_TIC     = 8'h0C;
	localparam logic [7:0] CMD_TIC_INT = 8'h04;
	localparam logic [7:0] CMD_ECHO    = 8'h10;
	localparam logic [7:0] CMD_PAR_EN  = 8'h20;
	localparam logic [7:0] CMD_PAR_SEL = 8'hC0;
	localparam logic [7:0] CMD_PAR_ODD  = 8'h00;
	localparam logic [7:0] CMD_PAR_EVEN = 8'h40;
	localparam logic [7:0] CMD_PRG_RESET_KEEP = 8'hE0;

	// parity mode codes
	localparam logic [1:0] PAR_NONE = 2'd0;
	localparam logic [1:0] PAR_ODD  = 2'd1;
	localparam logic [1:0] PAR_EVEN = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] reg_addr;
		logic [7:0] write_data;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_overrun;
		logic       line_ready;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        irq;
		logic        line_valid;
		logic [7:0]  line_byte;
		logic        rx_taken;
		logic        usb_echo;
		logic        usb_tx_valid;
		logic [7:0]  usb_tx_byte;
		logic [14:0] baud_rate;
		logic [3:0]  word_bits;
		logic        stop_two;
		logic [1:0]  parity_mode;
	} rsp_t;

	// line rate from control bits 3..0
	function automatic logic [14:0] baud_rate_f(input logic [3:0] sel);
		logic [14:0] r;
		case (sel)
			4'd0:    r = 15'd19200;
			4'd1:    r = 15'd50;
			4'd2:    r = 15'd75;
			4'd3:    r = 15'd110;
			4'd4:    r = 15'd135;
			4'd5:    r = 15'd150;
			4'd6:    r = 15'd300;
			4'd7:    r = 15'd600;
			4'd8:    r = 15'd1200;
			4'd9:    r = 15'd1800;
			4'd10:   r = 15'd2400;
			4'd11:   r = 15'd3600;
			4'd12:   r = 15'd4800;
			4'd13:   r = 15'd7200;
			4'd14:   r = 15'd9600;
			default: r = 15'd19200;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/aciasp_qmem.sv
// transmit queue storage: one write port, one registered read port
// depends on aciasp_pkg for the default queue depth
module aciasp_qmem
	import aciasp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/acia_serial_port_registers_core.sv
// top level of the acia serial port register block with its transmit queue
// depends on aciasp_pkg and aciasp_qmem
//
// One request per clock: bus reads, bus writes and ticks are taken back to back and each gives
// exactly one response, offered once it reaches the output register through stage one (the
// accepting edge loads the register update and the queue memory read into stage one, which passes
// it on once the output is free). Throughput is one request per cycle as long as responses are
// taken; the input stalls only when both stage one and the output register are full. A tick
// that both echoes a received byte and moves the held transmit byte into the queue needs two
// writes; the second goes to a one-entry write buffer that drains on the next write port slot,
// so the single write port of the queue memory never slows the input. The queue holds up to
// QUEUE_DEPTH-1 bytes; its entries need no clearing after reset, since only entries written
// since then are ever sent.
module acia_serial_port_registers_core
	import aciasp_pkg::*;
#(
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
	parameter int POLL_INTERVAL = POLL_INTERVAL_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int PCW = (POLL_INTERVAL > 1) ? $clog2(POLL_INTERVAL) : 1;

	function automatic logic [QW-1:0] qnext(input logic [QW-1:0] i);
		return (i == QW'(QUEUE_DEPTH - 1)) ? '0 : i + QW'(1);
	endfunction

	// architectural registers
	logic [7:0]     tx_hold_q, rx_data_q, command_q, control_q, status_q;
	logic           tx_waiting_q;
	logic [PCW-1:0] poll_q;
	logic [QW-1:0]  head_q, tail_q;

	// write buffer for the second queue push of a tick
	logic           pend_v_q;
	logic [QW-1:0]  pend_addr_q;
	logic [7:0]     pend_data_q;

	// next-state values
	logic [7:0]     tx_hold_n, rx_data_n, command_n, control_n, status_n;
	logic           tx_waiting_n;
	logic [PCW-1:0] poll_n;
	logic [QW-1:0]  head_a, head_n, tail_n;
	logic           push_a, push_b, pop;
	logic           fwd_echo;
	rsp_t           res;

	// memory write port and buffer update
	logic           mem_we;
	logic [QW-1:0]  mem_waddr;
	logic [7:0]     mem_wdata;
	logic           pend_v_n;
	logic [QW-1:0]  pend_addr_n;
	logic [7:0]     pend_data_n;
	logic [7:0]     mem_rdata;

	// pipeline
	logic           acc;
	logic           out_adv, s1_adv;
	logic           valid_s1;
	rsp_t           res_s1;
	logic           fwd_sel_s1;
	logic [7:0]     fwd_byte_s1;
	logic           fwd_sel;
	logic [7:0]     fwd_byte;
	rsp_t           rsp_n;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	assign out_adv   = !rsp_valid_q || rsp_ready;
	assign s1_adv    = valid_s1 && out_adv;
	assign req_ready = !valid_s1 || out_adv;
	assign acc       = req_valid && req_ready;

	// register update for one request
	always_comb begin
		tx_hold_n    = tx_hold_q;
		rx_data_n    = rx_data_q;
		command_n    = command_q;
		control_n    = control_q;
		status_n     = status_q;
		tx_waiting_n = tx_waiting_q;
		poll_n       = poll_q;
		head_a       = head_q;
		head_n       = head_q;
		tail_n       = tail_q;
		push_a       = 1'b0;
		push_b       = 1'b0;
		pop          = 1'b0;
		fwd_echo     = 1'b0;
		res          = '0;

		case (req.req_type)
			REQ_READ: begin
				case (req.reg_addr)
					ADDR_DATA: begin
						res.read_data = rx_data_q;
						status_n = status_q & ~(ST_IRQ | ST_RDRF | ST_OVR | ST_FE | ST_PE);
					end
					ADDR_STATUS: begin
						// modem inputs read as inactive
						res.read_data = status_q & ~(ST_DCD | ST_DSR);
						status_n = status_q & ~ST_IRQ;
					end
					ADDR_COMMAND: res.read_data = command_q;
					default:      res.read_data = control_q;
				endcase
			end
			REQ_WRITE: begin
				case (req.reg_addr)
					ADDR_DATA: begin
						tx_hold_n    = req.write_data;
						status_n     = status_q & ~ST_TDRE;
						tx_waiting_n = 1'b1;
					end
					ADDR_STATUS: begin
						// programmed reset
						command_n = command_q & CMD_PRG_RESET_KEEP;
						status_n  = status_q & ~ST_OVR;
					end
					ADDR_COMMAND: command_n = req.write_data;
					default:      control_n = req.write_data;
				endcase
			end
			REQ_TICK: begin
				// receive poll
				if (poll_q == PCW'(POLL_INTERVAL - 1)) begin
					poll_n = '0;
					if ((command_q & CMD_DTR) != '0) begin
						if (req.rx_overrun) begin
							status_n = status_n | ST_OVR;
						end
						if ((status_q & ST_RDRF) == '0 && req.rx_valid) begin
							rx_data_n    = req.rx_byte;
							status_n     = status_n | ST_RDRF;
							res.rx_taken = 1'b1;
							if ((command_q & CMD_ECHO) != '0) begin
								res.usb_echo = 1'b1;
								if (qnext(head_q) != tail_q) begin
									push_a = 1'b1;
									head_a = qnext(head_q);
								end
							end
							if ((command_q & CMD_IRD) == '0) begin
								status_n = status_n | ST_IRQ;
							end
						end
					end
				end else begin
					poll_n = poll_q + PCW'(1);
				end
				// one queued byte to the line
				if (head_a != tail_q && req.line_ready) begin
					pop             = 1'b1;
					res.line_valid  = 1'b1;
					tail_n          = qnext(tail_q);
					// an echo pushed into an empty queue goes straight out
					fwd_echo        = push_a && (head_q == tail_q);
				end
				head_n = head_a;
				// held byte into the queue when the transmitter is on
				if (tx_waiting_q && (command_q & CMD_DTR) != '0 && (command_q & CMD_TIC) != '0
					&& qnext(head_a) != tail_n) begin
					push_b           = 1'b1;
					head_n           = qnext(head_a);
					res.usb_tx_valid = 1'b1;
					res.usb_tx_byte  = tx_hold_q;
					status_n         = status_n | ST_TDRE;
					tx_waiting_n     = 1'b0;
					if ((command_q & CMD_TIC) == CMD_TIC_INT) begin
						status_n = status_n | ST_IRQ;
					end
				end
			end
			default: ;
		endcase

		// outputs that follow the registers after the request
		res.irq         = ((command_n & CMD_DTR) != '0) && ((status_n & ST_IRQ) != '0);
		res.baud_rate   = baud_rate_f(control_n[3:0]);
		res.word_bits   = 4'd8 - {2'b00, control_n[6:5]};
		res.stop_two    = control_n[7];
		res.parity_mode = PAR_NONE;
		if ((command_n & CMD_PAR_EN) != '0) begin
			if ((command_n & CMD_PAR_SEL) == CMD_PAR_ODD) begin
				res.parity_mode = PAR_ODD;
			end else if ((command_n & CMD_PAR_SEL) == CMD_PAR_EVEN) begin
				res.parity_mode = PAR_EVEN;
			end
		end
	end

	// single write port: buffered entry first, then the echo, then the held byte
	always_comb begin
		logic pa, pb;
		pa          = acc && push_a;
		pb          = acc && push_b;
		mem_we      = 1'b0;
		mem_waddr   = head_q;
		mem_wdata   = req.rx_byte;
		pend_v_n    = 1'b0;
		pend_addr_n = head_a;
		pend_data_n = tx_hold_q;
		if (pend_v_q) begin
			mem_we    = 1'b1;
			mem_waddr = pend_addr_q;
			mem_wdata = pend_data_q;
			if (pa) begin
				pend_v_n    = 1'b1;
				pend_addr_n = head_q;
				pend_data_n = req.rx_byte;
			end else if (pb) begin
				pend_v_n = 1'b1;
			end
		end else if (pa) begin
			mem_we   = 1'b1;
			pend_v_n = pb;
		end else if (pb) begin
			mem_we    = 1'b1;
			mem_waddr = head_a;
			mem_wdata = tx_hold_q;
		end
	end

	// line byte source: just-pushed echo, buffered entry, or memory
	always_comb begin
		fwd_sel  = 1'b0;
		fwd_byte = req.rx_byte;
		if (fwd_echo) begin
			fwd_sel = 1'b1;
		end else if (pend_v_q && pend_addr_q == tail_q) begin
			fwd_sel  = 1'b1;
			fwd_byte = pend_data_q;
		end
	end

	aciasp_qmem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (QW)
	) u_qmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (acc && pop),
		.raddr (tail_q),
		.rdata (mem_rdata)
	);

	// register file and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_hold_q    <= '0;
			rx_data_q    <= '0;
			command_q    <= '0;
			control_q    <= '0;
			status_q     <= ST_RESET;
			tx_waiting_q <= 1'b0;
			poll_q       <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			pend_v_q     <= 1'b0;
		end else begin
			pend_v_q <= pend_v_n;
			if (acc) begin
				tx_hold_q    <= tx_hold_n;
				rx_data_q    <= rx_data_n;
				command_q    <= command_n;
				control_q    <= control_n;
				status_q     <= status_n;
				tx_waiting_q <= tx_waiting_n;
				poll_q       <= poll_n;
				head_q       <= head_n;
				tail_q       <= tail_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_n) begin
			pend_addr_q <= pend_addr_n;
			pend_data_q <= pend_data_n;
		end
	end

	// stage 1 and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// line byte joins the stage 1 result on its way to the output register
	always_comb begin
		rsp_n = res_s1;
		if (res_s1.line_valid) begin
			rsp_n.line_byte = fwd_sel_s1 ? fwd_byte_s1 : mem_rdata;
		end else begin
			rsp_n.line_byte = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1      <= res;
			fwd_sel_s1  <= fwd_sel;
			fwd_byte_s1 <= fwd_byte;
		end
		if (s1_adv) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the write buffer never has to hold two entries
	a_pend_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && pend_v_q && push_a && push_b))
		else $error("queue write buffer overflow");

	// a buffered entry drains on any cycle without a new push
	a_pend_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q && !(acc && (push_a || push_b))) |=> !pend_v_q)
		else $error("queue write buffer did not drain");

	// transmit data register empty flag mirrors the held byte
	a_tdre_tracks_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(((status_q & ST_TDRE) != '0) == !tx_waiting_q))
		else $error("TDRE out of step with held transmit byte");

endmodule
